[rtl/lmqs_pkg.sv]
package lmqs_pkg;

  localparam int MAX_LENGTH_DEF = 1024;

  localparam int VAL_W      = 11;
  localparam int LEN_W      = 11;
  localparam int POS_OUT_W  = 11;
  localparam int KIND_RES_W = 2;
  localparam int EPOCH_W    = 8;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  // input item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  // result kinds
  localparam logic [KIND_RES_W-1:0] RES_QUERY = 2'd0;
  localparam logic [KIND_RES_W-1:0] RES_FOUND = 2'd1;
  localparam logic [KIND_RES_W-1:0] RES_NONE  = 2'd2;
  localparam logic [KIND_RES_W-1:0] RES_UNEXP = 2'd3;

  // register index, taken from paddr[APB_AW-1:2]
  localparam logic REG_LENGTH = 1'b0;

  // position selects
  localparam logic [1:0] POS_ZERO  = 2'd0;
  localparam logic [1:0] POS_MID   = 2'd1;
  localparam logic [1:0] POS_LEFT  = 2'd2;
  localparam logic [1:0] POS_RIGHT = 2'd3;

  typedef struct packed {
    logic                  start;
    logic                  epoch_inc;
    logic                  write_reply;
    logic                  sweep_step;
    logic                  rd_en;
    logic [1:0]            rd_sel;
    logic                  mid_load;
    logic                  vmid_load;
    logic                  vleft_load;
    logic                  set_pending;
    logic                  narrow;
    logic                  out_load;
    logic [KIND_RES_W-1:0] out_kind;
    logic [1:0]            pos_sel;
  } lmqs_cmd_t;

  typedef struct packed {
    logic bounds_crossed;
    logic hit;
    logic left_end;
    logic right_end;
    logic is_min;
    logic awaiting;
    logic epoch_full;
    logic sweep_last;
    logic out_free;
  } lmqs_sts_t;

endpackage

[rtl/local_minimum_query_search.sv]
// Local-minimum search over a hidden sequence, driven by a partner that
// answers value queries by position.
// Input channel (in_valid/in_ready): in_kind start=0 begins a new search over
// positions 1..length, reply=1 carries in_reply_value for the pending query.
// Result channel (out_valid/out_ready): exactly one beat per input beat,
// out_kind_res query / found / none / unexpected with out_position.
// APB port: register 0 at address 0 is length (11 bits), sampled at start.
// An input beat is taken only in the idle state, and one item is in flight
// at a time. Each probe of a narrowing step takes its own cache read (the
// cache has a single read port); the first probe not yet cached is sent out
// as a query.
// Cached values carry an 8-bit search tag instead of per-entry valid bits.
// After reset the cache is swept, all MAX_LENGTH+2 entries, with in_ready low.
// Each time the tag wraps (the 256th start, then every 255th) the same sweep
// runs after the start beat before its first result.
// A stalled receiver holds the result in the output register; the block
// still takes the next input beat, but waits before writing another result.
module local_minimum_query_search #(
  parameter int MAX_LENGTH = lmqs_pkg::MAX_LENGTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_kind,
  input  logic [lmqs_pkg::VAL_W-1:0]        in_reply_value,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lmqs_pkg::KIND_RES_W-1:0]   out_kind_res,
  output logic [lmqs_pkg::POS_OUT_W-1:0]    out_position,
  // APB config
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lmqs_pkg::APB_AW-1:0]       paddr,
  input  logic [lmqs_pkg::APB_DW-1:0]       pwdata,
  output logic [lmqs_pkg::APB_DW-1:0]       prdata,
  output logic                              pready
);

  logic [lmqs_pkg::LEN_W-1:0] length_r;
  logic [lmqs_pkg::LEN_W-1:0] length_nxt;
  logic                       reg_sel;
  lmqs_pkg::lmqs_cmd_t        cmd;
  lmqs_pkg::lmqs_sts_t        sts;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[lmqs_pkg::APB_AW-1:2] == lmqs_pkg::REG_LENGTH);

  always_comb begin
    length_nxt = length_r;
    if (psel && penable && pwrite && pready && reg_sel) begin
      length_nxt = pwdata[lmqs_pkg::LEN_W-1:0];
    end
  end

  // length resets to 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r <= lmqs_pkg::LEN_W'(1);
    end else begin
      length_r <= length_nxt;
    end
  end

  assign prdata = reg_sel ? lmqs_pkg::APB_DW'(length_r) : '0;

  // sequencing: idle / sweep / probe reads / result
  lmqs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // bounds, value cache, compare and output register
  lmqs_dp #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .length         (length_r),
    .in_reply_value (in_reply_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind_res   (out_kind_res),
    .out_position   (out_position)
  );

endmodule

[rtl/lmqs_ram.sv]
module lmqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/lmqs_ctrl.sv]
module lmqs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_kind,
  output logic                in_ready,
  input  lmqs_pkg::lmqs_sts_t sts,
  output lmqs_pkg::lmqs_cmd_t cmd
);

  localparam logic [2:0] ST_SWEEP_RST = 3'd0;
  localparam logic [2:0] ST_IDLE      = 3'd1;
  localparam logic [2:0] ST_SWEEP_ST  = 3'd2;
  localparam logic [2:0] ST_STEP      = 3'd3;
  localparam logic [2:0] ST_RD_M      = 3'd4;
  localparam logic [2:0] ST_RD_L      = 3'd5;
  localparam logic [2:0] ST_RD_R      = 3'd6;
  localparam logic [2:0] ST_UNEXP     = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SWEEP_RST;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_SWEEP_RST: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_kind == lmqs_pkg::KIND_START) begin
            cmd.start     = 1'b1;
            cmd.epoch_inc = 1'b1;
            state_nxt     = sts.epoch_full ? ST_SWEEP_ST : ST_STEP;
          end else if (sts.awaiting) begin
            cmd.write_reply = 1'b1;
            state_nxt       = ST_STEP;
          end else begin
            state_nxt = ST_UNEXP;
          end
        end
      end
      ST_SWEEP_ST: begin
        // tags wrapped: wipe them, then move off the reserved epoch
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          cmd.epoch_inc = 1'b1;
          state_nxt     = ST_STEP;
        end
      end
      ST_STEP: begin
        if (sts.bounds_crossed) begin
          if (sts.out_free) begin
            cmd.out_load = 1'b1;
            cmd.out_kind = lmqs_pkg::RES_NONE;
            cmd.pos_sel  = lmqs_pkg::POS_ZERO;
            state_nxt    = ST_IDLE;
          end
        end else begin
          cmd.rd_en    = 1'b1;
          cmd.rd_sel   = lmqs_pkg::POS_MID;
          cmd.mid_load = 1'b1;
          state_nxt    = ST_RD_M;
        end
      end
      ST_RD_M: begin
        if (!sts.hit) begin
          if (sts.out_free) begin
            cmd.out_load    = 1'b1;
            cmd.out_kind    = lmqs_pkg::RES_QUERY;
            cmd.pos_sel     = lmqs_pkg::POS_MID;
            cmd.set_pending = 1'b1;
            state_nxt       = ST_IDLE;
          end
        end else begin
          cmd.vmid_load = 1'b1;
          cmd.rd_en     = 1'b1;
          cmd.rd_sel    = lmqs_pkg::POS_LEFT;
          state_nxt     = ST_RD_L;
        end
      end
      ST_RD_L: begin
        if (!(sts.hit || sts.left_end)) begin
          if (sts.out_free) begin
            cmd.out_load    = 1'b1;
            cmd.out_kind    = lmqs_pkg::RES_QUERY;
            cmd.pos_sel     = lmqs_pkg::POS_LEFT;
            cmd.set_pending = 1'b1;
            state_nxt       = ST_IDLE;
          end
        end else begin
          cmd.vleft_load = 1'b1;
          cmd.rd_en      = 1'b1;
          cmd.rd_sel     = lmqs_pkg::POS_RIGHT;
          state_nxt      = ST_RD_R;
        end
      end
      ST_RD_R: begin
        if (!(sts.hit || sts.right_end)) begin
          if (sts.out_free) begin
            cmd.out_load    = 1'b1;
            cmd.out_kind    = lmqs_pkg::RES_QUERY;
            cmd.pos_sel     = lmqs_pkg::POS_RIGHT;
            cmd.set_pending = 1'b1;
            state_nxt       = ST_IDLE;
          end
        end else if (sts.is_min) begin
          if (sts.out_free) begin
            cmd.out_load = 1'b1;
            cmd.out_kind = lmqs_pkg::RES_FOUND;
            cmd.pos_sel  = lmqs_pkg::POS_MID;
            state_nxt    = ST_IDLE;
          end
        end else begin
          cmd.narrow = 1'b1;
          state_nxt  = ST_STEP;
        end
      end
      ST_UNEXP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = lmqs_pkg::RES_UNEXP;
          cmd.pos_sel  = lmqs_pkg::POS_ZERO;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_SWEEP_RST;
      end
    endcase
  end

endmodule

[rtl/lmqs_dp.sv]
module lmqs_dp #(
  parameter int MAX_LENGTH = lmqs_pkg::MAX_LENGTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lmqs_pkg::lmqs_cmd_t               cmd,
  output lmqs_pkg::lmqs_sts_t               sts,
  input  logic [lmqs_pkg::LEN_W-1:0]        length,
  input  logic [lmqs_pkg::VAL_W-1:0]        in_reply_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lmqs_pkg::KIND_RES_W-1:0]   out_kind_res,
  output logic [lmqs_pkg::POS_OUT_W-1:0]    out_position
);

  localparam int DEPTH = MAX_LENGTH + 2;
  localparam int PW    = $clog2(DEPTH);
  localparam int VW    = lmqs_pkg::VAL_W;
  localparam int EW    = lmqs_pkg::EPOCH_W;
  localparam int MW    = EW + VW;

  logic [PW-1:0] low_r, low_nxt;
  logic [PW-1:0] high_r, high_nxt;
  logic [PW-1:0] slen_r, slen_nxt;
  logic [PW-1:0] mid_r, mid_nxt;
  logic [PW-1:0] pend_r, pend_nxt;
  logic [PW-1:0] sweep_r, sweep_nxt;
  logic          await_r, await_nxt;
  logic [EW-1:0] epoch_r, epoch_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [VW-1:0] vmid_r;
  logic [VW-1:0] vleft_r;
  logic [lmqs_pkg::KIND_RES_W-1:0] out_kind_r;
  logic [PW-1:0] out_pos_r;

  logic [31:0]   len_ext;
  logic [PW-1:0] len_sat;
  logic [PW-1:0] mid_comb;
  logic [PW-1:0] left_pos;
  logic [PW-1:0] right_pos;
  logic [PW-1:0] sel_pos;
  logic [PW-1:0] rd_addr;
  logic          ram_we;
  logic [PW-1:0] ram_waddr;
  logic [MW-1:0] ram_wdata;
  logic [MW-1:0] ram_rdata;
  logic [EW-1:0] rd_tag;
  logic [VW-1:0] rd_val;
  logic          left_end;
  logic          right_end;
  logic          sweep_last;
  logic          out_free;

  assign len_ext = 32'(length);
  assign len_sat = (len_ext > 32'(MAX_LENGTH)) ? PW'(MAX_LENGTH) : PW'(len_ext);

  assign mid_comb  = low_r + ((high_r - low_r) >> 1);
  assign left_pos  = mid_r - PW'(1);
  assign right_pos = mid_r + PW'(1);

  always_comb begin
    case (cmd.pos_sel)
      lmqs_pkg::POS_MID:   sel_pos = mid_r;
      lmqs_pkg::POS_LEFT:  sel_pos = left_pos;
      lmqs_pkg::POS_RIGHT: sel_pos = right_pos;
      default:             sel_pos = '0;
    endcase
  end

  // the middle probe is read in the same cycle its bounds settle
  always_comb begin
    case (cmd.rd_sel)
      lmqs_pkg::POS_LEFT:  rd_addr = left_pos;
      lmqs_pkg::POS_RIGHT: rd_addr = right_pos;
      default:             rd_addr = mid_comb;
    endcase
  end

  assign ram_we    = cmd.sweep_step | cmd.write_reply;
  assign ram_waddr = cmd.sweep_step ? sweep_r : pend_r;
  assign ram_wdata = cmd.sweep_step ? '0 : {epoch_r, in_reply_value};

  lmqs_ram #(
    .WIDTH (MW),
    .DEPTH (DEPTH)
  ) u_cache (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign rd_tag     = ram_rdata[MW-1:VW];
  assign rd_val     = ram_rdata[VW-1:0];
  assign left_end   = (mid_r == PW'(1));
  assign right_end  = (mid_r == slen_r);
  assign sweep_last = (sweep_r == PW'(DEPTH - 1));
  assign out_free   = !out_valid_r || out_ready;

  assign sts.bounds_crossed = (low_r > high_r);
  assign sts.hit            = (rd_tag == epoch_r);
  assign sts.left_end       = left_end;
  assign sts.right_end      = right_end;
  assign sts.is_min         = (left_end || (vmid_r < vleft_r)) &&
                              (right_end || (vmid_r < rd_val));
  assign sts.awaiting       = await_r;
  assign sts.epoch_full     = &epoch_r;
  assign sts.sweep_last     = sweep_last;
  assign sts.out_free       = out_free;

  always_comb begin
    low_nxt       = low_r;
    high_nxt      = high_r;
    slen_nxt      = slen_r;
    mid_nxt       = mid_r;
    pend_nxt      = pend_r;
    sweep_nxt     = sweep_r;
    await_nxt     = await_r;
    epoch_nxt     = epoch_r;
    out_valid_nxt = out_valid_r;

    if (cmd.start) begin
      slen_nxt  = len_sat;
      low_nxt   = PW'(1);
      high_nxt  = len_sat;
      pend_nxt  = '0;
      await_nxt = 1'b0;
    end
    if (cmd.epoch_inc) begin
      epoch_nxt = epoch_r + EW'(1);
    end
    if (cmd.write_reply) begin
      await_nxt = 1'b0;
    end
    if (cmd.sweep_step) begin
      sweep_nxt = sweep_last ? '0 : sweep_r + PW'(1);
    end
    if (cmd.mid_load) begin
      mid_nxt = mid_comb;
    end
    if (cmd.set_pending) begin
      pend_nxt  = sel_pos;
      await_nxt = 1'b1;
    end
    if (cmd.narrow) begin
      // left neighbor strictly below middle: go left, else right
      if (!left_end && (vleft_r < vmid_r)) begin
        high_nxt = left_pos;
      end else begin
        low_nxt = right_pos;
      end
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r       <= '0;
      high_r      <= '0;
      slen_r      <= '0;
      mid_r       <= '0;
      pend_r      <= '0;
      sweep_r     <= '0;
      await_r     <= 1'b0;
      epoch_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      slen_r      <= slen_nxt;
      mid_r       <= mid_nxt;
      pend_r      <= pend_nxt;
      sweep_r     <= sweep_nxt;
      await_r     <= await_nxt;
      epoch_r     <= epoch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.vmid_load) begin
      vmid_r <= rd_val;
    end
    if (cmd.vleft_load) begin
      vleft_r <= rd_val;
    end
    if (cmd.out_load) begin
      out_kind_r <= cmd.out_kind;
      out_pos_r  <= sel_pos;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind_res = out_kind_r;
  assign out_position = lmqs_pkg::POS_OUT_W'(32'(out_pos_r));

endmodule

[rtl/lmqs_checker.sv]
module lmqs_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [lmqs_pkg::KIND_RES_W-1:0]  out_kind_res,
  input logic [lmqs_pkg::POS_OUT_W-1:0]   out_position
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind_res) && $stable(out_position))
    else $error("result beat changed while stalled");

  // none found and unexpected reply carry position zero
  a_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind_res == lmqs_pkg::RES_NONE || out_kind_res == lmqs_pkg::RES_UNEXP)
    |-> out_position == '0)
    else $error("nonzero position on none/unexpected");

  // a found minimum lies inside the sequence, never at position zero
  a_found_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind_res == lmqs_pkg::RES_FOUND |-> out_position != '0)
    else $error("found minimum at position zero");

  // one item at a time: busy right after an input beat
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken in back-to-back cycles");

  // reset empties the output register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind local_minimum_query_search lmqs_checker u_lmqs_checker (.*);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  // Local-minimum search block, checked beat by beat.
  // The sender plays the partner: it answers most queries from a hidden
  // sequence, using the position that the local copy of the search predicts,
  // so replies can stream without waiting for the result channel.
  // Every accepted input beat queues one expected result. The receiver pops
  // it and compares both fields.

  localparam int MAXL        = lmqs_pkg::MAX_LENGTH_DEF;
  localparam int ITEM_TARGET = 1900;
  // No beat for this many cycles means the block hung. The worst legal quiet
  // stretch is a cache sweep or the long receiver hold-off.
  localparam int STALL_LIMIT = 6000;
  localparam int LONG_HOLD   = 400;

  typedef struct packed {
    logic [lmqs_pkg::KIND_RES_W-1:0] kind_res;
    logic [lmqs_pkg::POS_OUT_W-1:0]  position;
  } answer_t;

  // Directed rows: free rows are checked against the local search copy,
  // typed rows carry their expected result, length rows write the register.
  typedef enum logic [1:0] {ROW_FREE, ROW_TYPED, ROW_LENGTH} row_op_t;

  typedef struct packed {
    row_op_t                         op;
    logic                            kind;
    logic [lmqs_pkg::VAL_W-1:0]      data;
    logic [lmqs_pkg::KIND_RES_W-1:0] exp_kind;
    logic [lmqs_pkg::POS_OUT_W-1:0]  exp_pos;
  } row_t;

  localparam row_t SCRIPT [26] = '{
    // reply before any search was started
    '{ROW_TYPED,  lmqs_pkg::KIND_REPLY, 11'd5,    lmqs_pkg::RES_UNEXP, 11'd0},
    // reset length is 1: one query, then the single position is the minimum
    '{ROW_TYPED,  lmqs_pkg::KIND_START, 11'd0,    lmqs_pkg::RES_QUERY, 11'd1},
    '{ROW_TYPED,  lmqs_pkg::KIND_REPLY, 11'd2047, lmqs_pkg::RES_FOUND, 11'd1},
    // reply after the search has ended
    '{ROW_TYPED,  lmqs_pkg::KIND_REPLY, 11'd0,    lmqs_pkg::RES_UNEXP, 11'd0},
    // length 0: bounds cross at once
    '{ROW_LENGTH, lmqs_pkg::KIND_START, 11'd0,    lmqs_pkg::RES_QUERY, 11'd0},
    '{ROW_TYPED,  lmqs_pkg::KIND_START, 11'd0,    lmqs_pkg::RES_NONE,  11'd0},
    // oversized length saturates, middle of 1..1024 is 512; zero value kept
    '{ROW_LENGTH, lmqs_pkg::KIND_START, 11'd2047, lmqs_pkg::RES_QUERY, 11'd0},
    '{ROW_TYPED,  lmqs_pkg::KIND_START, 11'd0,    lmqs_pkg::RES_QUERY, 11'd512},
    '{ROW_TYPED,  lmqs_pkg::KIND_REPLY, 11'd0,    lmqs_pkg::RES_QUERY, 11'd511},
    '{ROW_TYPED,  lmqs_pkg::KIND_REPLY, 11'd1,    lmqs_pkg::RES_QUERY, 11'd513},
    '{ROW_TYPED,  lmqs_pkg::KIND_REPLY, 11'd2047, lmqs_pkg::RES_FOUND, 11'd512},
    // equal neighbors never count as below: search walks off the right end
    '{ROW_LENGTH, lmqs_pkg::KIND_START, 11'd2,    lmqs_pkg::RES_QUERY, 11'd0},
    '{ROW_TYPED,  lmqs_pkg::KIND_START, 11'd0,    lmqs_pkg::RES_QUERY, 11'd1},
    '{ROW_TYPED,  lmqs_pkg::KIND_REPLY, 11'd7,    lmqs_pkg::RES_QUERY, 11'd2},
    '{ROW_TYPED,  lmqs_pkg::KIND_REPLY, 11'd7,    lmqs_pkg::RES_NONE,  11'd0},
    // restart while a query is open
    '{ROW_LENGTH, lmqs_pkg::KIND_START, 11'd3,    lmqs_pkg::RES_QUERY, 11'd0},
    '{ROW_TYPED,  lmqs_pkg::KIND_START, 11'd0,    lmqs_pkg::RES_QUERY, 11'd2},
    '{ROW_TYPED,  lmqs_pkg::KIND_START, 11'd0,    lmqs_pkg::RES_QUERY, 11'd2},
    '{ROW_TYPED,  lmqs_pkg::KIND_REPLY, 11'd5,    lmqs_pkg::RES_QUERY, 11'd1},
    // length rewritten mid-search: right end stays at 3 until the next start
    '{ROW_LENGTH, lmqs_pkg::KIND_START, 11'd1024, lmqs_pkg::RES_QUERY, 11'd0},
    '{ROW_TYPED,  lmqs_pkg::KIND_REPLY, 11'd3,    lmqs_pkg::RES_QUERY, 11'd3},
    '{ROW_TYPED,  lmqs_pkg::KIND_REPLY, 11'd9,    lmqs_pkg::RES_FOUND, 11'd1},
    // start payload is ignored; then a narrowing step to the left
    '{ROW_TYPED,  lmqs_pkg::KIND_START, 11'd2047, lmqs_pkg::RES_QUERY, 11'd512},
    '{ROW_TYPED,  lmqs_pkg::KIND_REPLY, 11'd1024, lmqs_pkg::RES_QUERY, 11'd511},
    '{ROW_TYPED,  lmqs_pkg::KIND_REPLY, 11'd1023, lmqs_pkg::RES_QUERY, 11'd513},
    '{ROW_FREE,   lmqs_pkg::KIND_REPLY, 11'd1025, lmqs_pkg::RES_QUERY, 11'd0}
  };

  logic                            clk            = 1'b0;
  logic                            rst_n          = 1'b0;
  logic                            in_valid       = 1'b0;
  logic                            in_ready;
  logic                            in_kind        = lmqs_pkg::KIND_START;
  logic [lmqs_pkg::VAL_W-1:0]      in_reply_value = '0;
  logic                            out_valid;
  logic                            out_ready      = 1'b0;
  logic [lmqs_pkg::KIND_RES_W-1:0] out_kind_res;
  logic [lmqs_pkg::POS_OUT_W-1:0]  out_position;
  logic                            psel           = 1'b0;
  logic                            penable        = 1'b0;
  logic                            pwrite         = 1'b0;
  logic [lmqs_pkg::APB_AW-1:0]     paddr          = '0;
  logic [lmqs_pkg::APB_DW-1:0]     pwdata         = '0;
  logic [lmqs_pkg::APB_DW-1:0]     prdata;
  logic                            pready;

  local_minimum_query_search dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_reply_value (in_reply_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind_res   (out_kind_res),
    .out_position   (out_position),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Local copy of the search state
  // ---------------------------------------------------------------------
  logic [lmqs_pkg::LEN_W-1:0] len_reg = lmqs_pkg::LEN_W'(1);
  logic [lmqs_pkg::VAL_W-1:0] seen_val [0:MAXL+1] = '{default: '0};
  bit                         seen     [0:MAXL+1];
  int                         lo_pos    = 0;
  int                         hi_pos    = 0;
  int                         asked_pos = 0;
  int                         span      = 0;   // length latched at start
  bit                         awaiting  = 1'b0;

  // hidden sequence the partner answers from
  logic [lmqs_pkg::VAL_W-1:0] hidden_seq [0:MAXL+1] = '{default: '0};

  answer_t answers_due [$];
  answer_t last_answer;
  int      fault_count = 0;
  int      beats_sent  = 0;
  int      hold_cycles = 0;
  bit      gaps_on     = 1'b1;
  int      quiet_cycles = 0;

  // the two end positions always count as known and above any value
  function automatic bit at_end(int p);
    return p == 0 || p == span + 1;
  endfunction

  function automatic bit is_seen(int p);
    return at_end(p) || p > MAXL + 1 || seen[p];
  endfunction

  function automatic bit lower(int a, int b);
    if (at_end(a) || a > MAXL + 1) return 1'b0;
    if (at_end(b) || b > MAXL + 1) return 1'b1;
    return seen_val[a] < seen_val[b];
  endfunction

  // Narrow until a probe is unknown (query), a minimum shows, or bounds cross.
  function automatic answer_t search_advance();
    int mid;
    int probe [3];
    while (lo_pos <= hi_pos) begin
      mid = lo_pos + (hi_pos - lo_pos) / 2;
      probe[0] = mid;
      probe[1] = mid - 1;
      probe[2] = mid + 1;
      foreach (probe[i]) begin
        if (!is_seen(probe[i])) begin
          asked_pos = probe[i];
          awaiting  = 1'b1;
          return '{lmqs_pkg::RES_QUERY, lmqs_pkg::POS_OUT_W'(probe[i])};
        end
      end
      if (lower(mid, mid - 1) && lower(mid, mid + 1)) begin
        awaiting = 1'b0;
        return '{lmqs_pkg::RES_FOUND, lmqs_pkg::POS_OUT_W'(mid)};
      end
      // ties go right
      if (lower(mid - 1, mid)) hi_pos = mid - 1;
      else lo_pos = mid + 1;
    end
    awaiting = 1'b0;
    return '{lmqs_pkg::RES_NONE, '0};
  endfunction

  function automatic answer_t search_step(logic k, logic [lmqs_pkg::VAL_W-1:0] v);
    int n;
    if (k == lmqs_pkg::KIND_START) begin
      n = (int'(len_reg) > MAXL) ? MAXL : int'(len_reg);
      foreach (seen[i]) seen[i] = 1'b0;
      span      = n;
      lo_pos    = 1;
      hi_pos    = n;
      asked_pos = 0;
      awaiting  = 1'b0;
      return search_advance();
    end
    // a stray reply leaves everything as it was
    if (!awaiting) return '{lmqs_pkg::RES_UNEXP, '0};
    seen_val[asked_pos] = v;
    seen[asked_pos]     = 1'b1;
    awaiting            = 1'b0;
    return search_advance();
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // One input beat. Valid stays up across back-to-back beats (gap 0), so
  // it sees a single assignment per time step.
  task automatic send_beat(input logic k, input logic [lmqs_pkg::VAL_W-1:0] v,
                           input bit typed = 1'b0, input answer_t typed_ans = '0);
    int      gap;
    answer_t ans;
    gap = gaps_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= k;
    in_reply_value <= v;
    do @(posedge clk); while (!in_ready);
    ans = search_step(k, v);
    answers_due.insert(answers_due.size(), typed ? typed_ans : ans);
    last_answer = ans;
    beats_sent++;
  endtask

  // Sender stops and waits for every outstanding result. It always waits on
  // the clock before returning, so valid is never dropped and raised in one step.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (answers_due.size() != 0);
  endtask

  // APB write: setup, then access; lands on the edge with pready high.
  task automatic write_length(input logic [lmqs_pkg::LEN_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {lmqs_pkg::REG_LENGTH, 2'b00};
    pwdata  <= lmqs_pkg::APB_DW'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    len_reg = v;
  endtask

  // mostly short sequences, a few at full size, and the out-of-range values
  function automatic logic [lmqs_pkg::LEN_W-1:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return lmqs_pkg::LEN_W'($urandom_range(1, 16));
    if (r < 88) return lmqs_pkg::LEN_W'($urandom_range(17, 128));
    if (r < 95) return lmqs_pkg::LEN_W'($urandom_range(129, MAXL - 1));
    if (r < 97) return lmqs_pkg::LEN_W'(MAXL);
    if (r < 98) return '0;
    return lmqs_pkg::LEN_W'($urandom_range(MAXL + 1, 2047));
  endfunction

  // distinct shuffles most of the time; monotonic runs push the search to
  // either end; a narrow value range forces ties
  function automatic void build_sequence();
    int pool [2048];
    int n, mode, base, j, t;
    n    = (int'(len_reg) > MAXL) ? MAXL : int'(len_reg);
    mode = $urandom_range(0, 9);
    base = $urandom_range(0, 1023);
    foreach (pool[i]) pool[i] = i;
    for (int i = 1; i <= n; i++) begin
      if (mode < 6) begin
        j = $urandom_range(i - 1, 2047);
        t = pool[i - 1];
        pool[i - 1] = pool[j];
        pool[j] = t;
        hidden_seq[i] = lmqs_pkg::VAL_W'(pool[i - 1]);
      end else if (mode == 6) begin
        hidden_seq[i] = lmqs_pkg::VAL_W'(base + i);
      end else if (mode == 7) begin
        hidden_seq[i] = lmqs_pkg::VAL_W'(2047 - base - i);
      end else begin
        hidden_seq[i] = lmqs_pkg::VAL_W'($urandom_range(0, 3));
      end
    end
  endfunction

  // ---------------------------------------------------------------------
  // Result side: random stalls, one long hold-off on request
  // ---------------------------------------------------------------------
  initial begin
    answer_t due;
    int      stall;
    wait (rst_n);
    forever begin
      stall = gaps_on ? $urandom_range(0, 5) : 0;
      if (hold_cycles > 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (answers_due.size() == 0) begin
        $error("result beat with nothing expected: kind_res %0d position %0d",
               out_kind_res, out_position);
        fault_count++;
      end else begin
        due = answers_due.pop_front();
        if (out_kind_res !== due.kind_res) begin
          $error("kind_res: expected %0d, actual %0d", due.kind_res, out_kind_res);
          fault_count++;
        end
        if (out_position !== due.position) begin
          $error("position: expected %0d, actual %0d", due.position, out_position);
          fault_count++;
        end
      end
    end
  end

  // hang detector: counts edges with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int pick;
    int holds_done;
    bit fresh_len;
    holds_done = 0;
    fresh_len  = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows; register writes only once the block has gone quiet
    foreach (SCRIPT[r]) begin
      if (SCRIPT[r].op == ROW_LENGTH) begin
        drain();
        write_length(SCRIPT[r].data);
      end else begin
        send_beat(SCRIPT[r].kind, SCRIPT[r].data, SCRIPT[r].op == ROW_TYPED,
                  '{SCRIPT[r].exp_kind, SCRIPT[r].exp_pos});
      end
    end

    // random searches, each played to its end by the partner
    while (beats_sent < ITEM_TARGET) begin
      // a stretch with no idling on either side
      gaps_on = !(beats_sent >= 900 && beats_sent < 1150);
      // long receiver hold-off while the sender keeps offering beats
      if ((holds_done == 0 && beats_sent >= 500) ||
          (holds_done == 1 && beats_sent >= 1500)) begin
        hold_cycles = LONG_HOLD;
        holds_done++;
      end
      if (fresh_len || $urandom_range(0, 3) == 0) begin
        drain();
        write_length(pick_length());
        fresh_len = 1'b0;
      end else if ($urandom_range(0, 19) == 0) begin
        drain();
      end
      build_sequence();
      send_beat(lmqs_pkg::KIND_START, lmqs_pkg::VAL_W'($urandom));
      while (last_answer.kind_res == lmqs_pkg::RES_QUERY) begin
        pick = $urandom_range(0, 99);
        if (pick == 0) begin
          // partner abandons the search and starts over
          send_beat(lmqs_pkg::KIND_START, lmqs_pkg::VAL_W'($urandom));
        end else if (pick == 1) begin
          // partner answers with junk
          send_beat(lmqs_pkg::KIND_REPLY, lmqs_pkg::VAL_W'($urandom));
        end else begin
          send_beat(lmqs_pkg::KIND_REPLY, hidden_seq[last_answer.position]);
        end
      end
      // stray reply after the search has closed
      if ($urandom_range(0, 7) == 0) begin
        send_beat(lmqs_pkg::KIND_REPLY, lmqs_pkg::VAL_W'($urandom));
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (fault_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
